// ----- hdl/ces_pkg.sv -----
`timescale 1ns / 1ps
// types and constants shared by the cascaded exponential smoother
// no dependencies

package ces_pkg;

   localparam int ORDER_WIDTH = 3;
   localparam logic [ORDER_WIDTH-1:0] ORDER_RESET = 3'd3;
   localparam logic [16:0] ALPHA_ONE = 17'h10000;

   typedef enum logic [1:0] {
      CMD_TICK      = 2'd0,
      CMD_SET_DEST  = 2'd1,
      CMD_SET_VALUE = 2'd2
   } command_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INDEX,
      ST_DGET,
      ST_FILL,
      ST_RD,
      ST_DIFF,
      ST_MUL,
      ST_ADD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic signed [31:0] y;
      logic signed [31:0] x;
   } point_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [7:0]         element_index;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic [16:0]        smoothing_factor;
      logic               last_element;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]         out_index;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic               out_last;
   } rsp_payload_type;

endpackage

// ----- hdl/ces_ram.sv -----
`timescale 1ns / 1ps
// generic single-write, single-read synchronous ram with registered read data
// no dependencies

module ces_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/cascaded_exponential_smoother_2d.sv -----
`timescale 1ns / 1ps
// cascaded exponential smoother: 2d points through up to STAGES first-order stages
// depends on ces_pkg and ces_ram
//
// usage:
//  - req channel (req_valid / req_stall / req_payload) carries one element per
//    transaction: tick, set destination or set value, with alpha from the host
//  - rsp channel (rsp_valid / rsp_stall / rsp_payload) returns at most one point
//    per request transaction; none is returned until the first event has ended
//  - csr_wr_en / csr_wr_data write the filter order; write only while idle
//  - one request is processed at a time; req_stall is high while it is in work
//  - with n = min(order, STAGES), a tick passes index reduction, destination read
//    and stage read, then difference, multiply and round-add per stage up to n,
//    then the result register; set value first rewrites every stage
//  - until the first event ends, a request fills each stage with its destination
//  - the stages run one after another: each stage needs difference,
//    multiply and round-add before it can drive the next, all through one
//    stage memory that is read one entry ahead of the write
//  - reset (synchronous) clears the state machine, the started flag, the order
//    register (to three) and rsp_valid; memory contents stay undefined
//  - a stalled result holds in the output register; the block waits for it to
//    drain before presenting the next one

module cascaded_exponential_smoother_2d #(
   parameter int MAX_POINTS = 256,
   parameter int STAGES     = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ces_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output ces_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_wr_en,
   input  logic [2:0]               csr_wr_data
);

   import ces_pkg::*;

   localparam int IW          = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int STAGE_DEPTH = STAGES * MAX_POINTS;
   localparam int SAW         = (STAGE_DEPTH > 1) ? $clog2(STAGE_DEPTH) : 1;
   localparam int KW          = $clog2(STAGES + 1);
   // reciprocal with 20 fraction bits, exact quotient for 8-bit indices
   localparam int RECIP       = ((1 << 20) + MAX_POINTS - 1) / MAX_POINTS;

   function automatic logic [SAW-1:0] stage_addr(input logic [KW-1:0] k,
                                                  input logic [IW-1:0] i);
      logic [SAW-1:0] base;
      base = SAW'(k) * SAW'(MAX_POINTS);
      return base + SAW'(i);
   endfunction

   // state and control registers
   state_type           state_ff, state_in;
   logic                started_ff, started_in;
   logic [2:0]          order_ff, order_in;
   logic [KW-1:0]       k_ff, k_in;
   logic [KW-1:0]       n_ff, n_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // item and datapath registers
   req_payload_type     item_ff, item_in;
   logic [8:0]          quo_ff, quo_in;
   logic [16:0]         alpha_ff, alpha_in;
   logic [IW-1:0]       idx_ff, idx_in;
   point_type           d_ff, d_in;
   point_type           out_pt_ff, out_pt_in;
   logic                neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [31:0]         mag_x_ff, mag_x_in, mag_y_ff, mag_y_in;
   logic [48:0]         prod_x_ff, prod_x_in, prod_y_ff, prod_y_in;
   rsp_payload_type     rsp_payload_ff, rsp_payload_in;

   // memory ports
   logic                dest_wr_en, dest_rd_en;
   logic [IW-1:0]       dest_addr;
   logic [63:0]         dest_rd_data;
   logic                stage_wr_en, stage_rd_en;
   logic [SAW-1:0]      stage_wr_addr, stage_rd_addr;
   logic [63:0]         stage_wr_data, stage_rd_data;

   // combinational helpers
   logic [28:0]         idx_prod;
   logic [20:0]         idx_rem;
   point_type           item_pt;
   point_type           s_rd;
   point_type           s_new;
   logic [32:0]         diff_x, diff_y, ndiff_x, ndiff_y;
   logic [48:0]         rnd_x, rnd_y;
   logic [33:0]         step_x, step_y, sum_x, sum_y;
   logic [KW-1:0]       k_next;

   ces_ram #(
      .WIDTH (64),
      .DEPTH (MAX_POINTS)
   ) u_dest_ram (
      .clock   (clock),
      .wr_en   (dest_wr_en),
      .wr_addr (dest_addr),
      .wr_data (64'(item_pt)),
      .rd_en   (dest_rd_en),
      .rd_addr (dest_addr),
      .rd_data (dest_rd_data)
   );

   ces_ram #(
      .WIDTH (64),
      .DEPTH (STAGE_DEPTH)
   ) u_stage_ram (
      .clock   (clock),
      .wr_en   (stage_wr_en),
      .wr_addr (stage_wr_addr),
      .wr_data (stage_wr_data),
      .rd_en   (stage_rd_en),
      .rd_addr (stage_rd_addr),
      .rd_data (stage_rd_data)
   );

   // index reduction: quotient at accept, remainder in the next cycle
   assign idx_prod = 29'(req_payload.element_index) * 29'(RECIP);
   assign idx_rem  = 21'(item_ff.element_index) - 21'(quo_ff) * 21'(MAX_POINTS);

   assign item_pt  = '{y: item_ff.coord_y, x: item_ff.coord_x};
   assign s_rd     = point_type'(stage_rd_data);
   assign k_next   = k_ff + 1'b1;

   // difference of stage and driver, as sign and magnitude
   assign diff_x  = {s_rd.x[31], s_rd.x} - {d_ff.x[31], d_ff.x};
   assign diff_y  = {s_rd.y[31], s_rd.y} - {d_ff.y[31], d_ff.y};
   assign ndiff_x = -diff_x;
   assign ndiff_y = -diff_y;

   // round to nearest, ties away from zero, then step from the driver
   assign rnd_x  = prod_x_ff + 49'd32768;
   assign rnd_y  = prod_y_ff + 49'd32768;
   assign step_x = neg_x_ff ? -{1'b0, rnd_x[48:16]} : {1'b0, rnd_x[48:16]};
   assign step_y = neg_y_ff ? -{1'b0, rnd_y[48:16]} : {1'b0, rnd_y[48:16]};
   assign sum_x  = {{2{d_ff.x[31]}}, d_ff.x} + step_x;
   assign sum_y  = {{2{d_ff.y[31]}}, d_ff.y} + step_y;
   assign s_new  = '{y: sum_y[31:0], x: sum_x[31:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         started_ff   <= 1'b0;
         order_ff     <= ORDER_RESET;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         started_ff   <= started_in;
         order_ff     <= order_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      quo_ff         <= quo_in;
      alpha_ff       <= alpha_in;
      n_ff           <= n_in;
      idx_ff         <= idx_in;
      d_ff           <= d_in;
      out_pt_ff      <= out_pt_in;
      neg_x_ff       <= neg_x_in;
      neg_y_ff       <= neg_y_in;
      mag_x_ff       <= mag_x_in;
      mag_y_ff       <= mag_y_in;
      prod_x_ff      <= prod_x_in;
      prod_y_ff      <= prod_y_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_comb begin
      state_in       = state_ff;
      started_in     = started_ff;
      order_in       = csr_wr_en ? csr_wr_data : order_ff;
      k_in           = k_ff;
      n_in           = n_ff;
      item_in        = item_ff;
      quo_in         = quo_ff;
      alpha_in       = alpha_ff;
      idx_in         = idx_ff;
      d_in           = d_ff;
      out_pt_in      = out_pt_ff;
      neg_x_in       = neg_x_ff;
      neg_y_in       = neg_y_ff;
      mag_x_in       = mag_x_ff;
      mag_y_in       = mag_y_ff;
      prod_x_in      = prod_x_ff;
      prod_y_in      = prod_y_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_payload_in = rsp_payload_ff;

      dest_wr_en     = 1'b0;
      dest_rd_en     = 1'b0;
      dest_addr      = idx_ff;
      stage_wr_en    = 1'b0;
      stage_rd_en    = 1'b0;
      stage_wr_addr  = stage_addr(k_ff, idx_ff);
      stage_rd_addr  = stage_addr(k_ff, idx_ff);
      stage_wr_data  = 64'(s_new);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_payload;
               quo_in   = idx_prod[28:20];
               alpha_in = (req_payload.smoothing_factor > ALPHA_ONE) ?
                          ALPHA_ONE : req_payload.smoothing_factor;
               n_in     = (32'(order_ff) > STAGES) ? KW'(STAGES) : KW'(order_ff);
               state_in = ST_INDEX;
            end
         end
         ST_INDEX: begin
            idx_in     = idx_rem[IW-1:0];
            dest_addr  = idx_rem[IW-1:0];
            dest_rd_en = 1'b1;
            dest_wr_en = (item_ff.command == CMD_SET_DEST);
            state_in   = ST_DGET;
         end
         ST_DGET: begin
            // a fresh destination bypasses the read, which returns the old entry
            d_in     = (item_ff.command == CMD_SET_DEST) ?
                       item_pt : point_type'(dest_rd_data);
            k_in     = '0;
            state_in = (!started_ff || item_ff.command == CMD_SET_VALUE) ?
                       ST_FILL : ST_RD;
         end
         ST_FILL: begin
            stage_wr_en   = 1'b1;
            stage_wr_data = started_ff ? 64'(item_pt) : 64'(d_ff);
            if (k_ff == KW'(STAGES - 1)) begin
               k_in = '0;
               if (started_ff) begin
                  state_in = ST_RD;
               end else begin
                  started_in = item_ff.last_element;
                  state_in   = ST_IDLE;
               end
            end else begin
               k_in = k_next;
            end
         end
         ST_RD: begin
            stage_rd_en = 1'b1;
            state_in    = ST_DIFF;
         end
         ST_DIFF: begin
            if (n_ff == '0) begin
               // no stage in use: report stage one as it stands
               out_pt_in = s_rd;
               state_in  = ST_EMIT;
            end else begin
               neg_x_in = diff_x[32];
               neg_y_in = diff_y[32];
               mag_x_in = diff_x[32] ? ndiff_x[31:0] : diff_x[31:0];
               mag_y_in = diff_y[32] ? ndiff_y[31:0] : diff_y[31:0];
               // fetch the next stage while this one finishes
               if (k_next < n_ff) begin
                  stage_rd_en   = 1'b1;
                  stage_rd_addr = stage_addr(k_next, idx_ff);
               end
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_x_in = 49'(mag_x_ff) * 49'(alpha_ff);
            prod_y_in = 49'(mag_y_ff) * 49'(alpha_ff);
            state_in  = ST_ADD;
         end
         ST_ADD: begin
            stage_wr_en = 1'b1;
            d_in        = s_new;
            if (k_next == n_ff) begin
               out_pt_in = s_new;
               state_in  = ST_EMIT;
            end else begin
               k_in     = k_next;
               state_in = ST_DIFF;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in             = 1'b1;
               rsp_payload_in.out_index = 8'(idx_ff);
               rsp_payload_in.out_x     = out_pt_ff.x;
               rsp_payload_in.out_y     = out_pt_ff.y;
               rsp_payload_in.out_last  = item_ff.last_element;
               k_in                     = '0;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // a result only ever follows the first completed event
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> started_ff)
      else $error("result produced before the first event ended");

   // stage loop never runs past the selected order
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD) |-> (k_ff < n_ff))
      else $error("stage update beyond filter order");

   // no memory write is issued between transactions
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (!stage_wr_en && !dest_wr_en))
      else $error("memory write while idle");

endmodule

// ----- tb/cascaded_exponential_smoother_2d_test.sv -----
`timescale 1ns / 1ps
// self-checking bench for the cascaded exponential smoother: directed table, then random phases
// depends on ces_pkg and cascaded_exponential_smoother_2d

module cascaded_exponential_smoother_2d_test;
   import ces_pkg::*;

   localparam int POINT_COUNT = 256;
   localparam int STAGE_COUNT = 5;
   localparam int SETTLE_CYCLES = 40;
   localparam int PHASES = 9;
   localparam int ITEMS_PER_PHASE = 147;
   localparam int DIRECTED_ROWS = 22;
   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam logic [31:0] COORD_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] COORD_MIN = 32'h8000_0000;
   localparam logic [16:0] ALPHA_TOP = 17'h1FFFF;
   localparam logic [16:0] ALPHA_HALF = 17'h08000;
   localparam logic [2:0] PHASE_ORDER [PHASES] = '{3'd5, 3'd0, 3'd7, 3'd1, 3'd2, 3'd6,
                                                   3'd4, 3'd3, 3'd5};

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  idx;
      logic [31:0] x;
      logic [31:0] y;
      logic [16:0] alpha;
      logic        last;
      logic [2:0]  order;
      logic        typed;
      logic [31:0] ex;
      logic [31:0] ey;
   } step_type;

   // the first four rows finish the opening event, so they emit nothing
   step_type steps [DIRECTED_ROWS] = '{
      '{CMD_SET_VALUE, 8'd0,   32'h0000_04D2, 32'hFFFF_FFFF, 17'd0,      1'b0, 3'd3, 1'b0, 0, 0},
      '{CMD_TICK,      8'd255, 32'h0,         32'h0,         ALPHA_ONE,  1'b0, 3'd3, 1'b0, 0, 0},
      '{CMD_SPARE,     8'd7,   32'h0,         32'h0,         17'd0,      1'b0, 3'd3, 1'b0, 0, 0},
      '{CMD_SET_DEST,  8'd0,   COORD_MAX,     COORD_MIN,     17'd0,      1'b1, 3'd3, 1'b0, 0, 0},
      '{CMD_TICK,      8'd0,   32'h0,         32'h0,         17'd12345,  1'b0, 3'd3, 1'b1,
        COORD_MAX, COORD_MIN},
      '{CMD_SET_VALUE, 8'd0,   COORD_MIN,     COORD_MAX,     ALPHA_ONE,  1'b0, 3'd3, 1'b1,
        COORD_MIN, COORD_MAX},
      '{CMD_TICK,      8'd0,   32'h0,         32'h0,         17'd0,      1'b1, 3'd3, 1'b1,
        COORD_MAX, COORD_MIN},
      '{CMD_SET_VALUE, 8'd0,   COORD_MIN,     COORD_MAX,     ALPHA_TOP,  1'b0, 3'd3, 1'b1,
        COORD_MIN, COORD_MAX},
      '{CMD_TICK,      8'd0,   32'h0,         32'h0,         ALPHA_HALF, 1'b0, 3'd3, 1'b0, 0, 0},
      '{CMD_SPARE,     8'd0,   32'h0,         32'h0,         17'd1,      1'b0, 3'd3, 1'b0, 0, 0},
      '{CMD_TICK,      8'd0,   32'h0,         32'h0,         17'd65535,  1'b1, 3'd3, 1'b0, 0, 0},
      '{CMD_SET_DEST,  8'd255, 32'h0,         32'h0,         17'd0,      1'b1, 3'd3, 1'b1, 0, 0},
      '{CMD_SET_VALUE, 8'd255, 32'h0000_0001, 32'hFFFF_FFFF, ALPHA_HALF, 1'b0, 3'd3, 1'b0, 0, 0},
      '{CMD_SET_VALUE, 8'd255, 32'h0000_0003, 32'hFFFF_FFFD, ALPHA_HALF, 1'b0, 3'd5, 1'b0, 0, 0},
      '{CMD_TICK,      8'd255, 32'h0,         32'h0,         ALPHA_HALF, 1'b1, 3'd0, 1'b0, 0, 0},
      '{CMD_SET_DEST,  8'd128, 32'h0001_0000, 32'hFFFF_0000, 17'd0,      1'b0, 3'd0, 1'b0, 0, 0},
      '{CMD_TICK,      8'd128, 32'h0,         32'h0,         17'd0,      1'b0, 3'd7, 1'b1,
        32'h0001_0000, 32'hFFFF_0000},
      '{CMD_TICK,      8'd128, 32'h0,         32'h0,         17'd40000,  1'b1, 3'd6, 1'b0, 0, 0},
      '{CMD_SET_VALUE, 8'd85,  32'h5555_5555, 32'hAAAA_AAAA, ALPHA_ONE,  1'b0, 3'd1, 1'b1,
        32'h5555_5555, 32'hAAAA_AAAA},
      '{CMD_TICK,      8'd170, 32'h0,         32'h0,         17'd20000,  1'b0, 3'd2, 1'b0, 0, 0},
      '{CMD_SPARE,     8'd255, 32'h0,         32'h0,         ALPHA_TOP,  1'b1, 3'd4, 1'b0, 0, 0},
      '{CMD_SET_DEST,  8'd0,   COORD_MIN,     COORD_MAX,     ALPHA_ONE,  1'b1, 3'd3, 1'b0, 0, 0}
   };

   logic            clock = 1'b0;
   logic            reset;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;
   logic            csr_wr_en;
   logic [2:0]      csr_wr_data;

   // smoother state as the bench sees it
   point_type       dest_point [POINT_COUNT];
   point_type       stage_point [STAGE_COUNT][POINT_COUNT];
   bit              event_seen;
   logic [2:0]      order_reg;

   rsp_payload_type smoothed_due [$];
   rsp_payload_type due_point;
   int              mismatch_count = 0;
   int              send_idle_pct;
   int              recv_idle_pct;

   cascaded_exponential_smoother_2d dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #4 clock = ~clock;

   // one first-order step: d + round((s - d) * alpha), ties away from zero
   function automatic logic signed [31:0] approach(input logic signed [31:0] s,
                                                   input logic signed [31:0] d,
                                                   input int unsigned alpha);
      longint diff;
      longint mag;
      longint q;
      diff = longint'(s) - longint'(d);
      mag = (diff < 0) ? -diff : diff;
      q = (mag * longint'(alpha) + 64'sd32768) >>> 16;
      return 32'(longint'(d) + ((diff < 0) ? -q : q));
   endfunction

   function automatic void advance_smoother(input req_payload_type r, output bit emits,
                                            output rsp_payload_type res);
      int unsigned alpha;
      int          n;
      int          sel;
      logic [7:0]  i;
      point_type   p;
      point_type   drv;
      i = r.element_index;
      p.x = r.coord_x;
      p.y = r.coord_y;
      alpha = 32'((r.smoothing_factor > ALPHA_ONE) ? ALPHA_ONE : r.smoothing_factor);
      n = (int'(order_reg) > STAGE_COUNT) ? STAGE_COUNT : int'(order_reg);
      emits = 1'b0;
      res = '0;
      if (r.command == CMD_SET_DEST) begin
         dest_point[i] = p;
      end else if (r.command == CMD_SET_VALUE) begin
         for (int k = 0; k < STAGE_COUNT; k++) stage_point[k][i] = p;
      end
      if (!event_seen) begin
         for (int k = 0; k < STAGE_COUNT; k++) stage_point[k][i] = dest_point[i];
         if (r.last_element) event_seen = 1'b1;
         return;
      end
      for (int k = 0; k < n; k++) begin
         drv = (k == 0) ? dest_point[i] : stage_point[k-1][i];
         stage_point[k][i].x = approach(stage_point[k][i].x, drv.x, alpha);
         stage_point[k][i].y = approach(stage_point[k][i].y, drv.y, alpha);
      end
      sel = (n <= 1) ? 0 : n - 1;
      emits = 1'b1;
      res.out_index = i;
      res.out_x = stage_point[sel][i].x;
      res.out_y = stage_point[sel][i].y;
      res.out_last = r.last_element;
   endfunction

   function automatic logic [31:0] random_coord();
      case ($urandom_range(3))
         0: return 32'($urandom_range(32'h80000)) - 32'h40000;
         1: case ($urandom_range(3))
               0: return COORD_MAX;
               1: return COORD_MIN;
               2: return 32'h0;
               default: return 32'hFFFF_FFFF;
            endcase
         default: return $urandom;
      endcase
   endfunction

   function automatic req_payload_type random_request();
      req_payload_type r;
      int              roll;
      roll = $urandom_range(99);
      if (roll < 50) r.command = CMD_TICK;
      else if (roll < 72) r.command = CMD_SET_DEST;
      else if (roll < 94) r.command = CMD_SET_VALUE;
      else r.command = CMD_SPARE;
      r.element_index = 8'($urandom_range(POINT_COUNT - 1));
      r.coord_x = random_coord();
      r.coord_y = random_coord();
      case ($urandom_range(9))
         0: r.smoothing_factor = 17'd0;
         1: r.smoothing_factor = ALPHA_ONE;
         2: r.smoothing_factor = 17'($urandom_range(ALPHA_TOP, ALPHA_ONE + 1));
         default: r.smoothing_factor = 17'($urandom_range(65535));
      endcase
      r.last_element = ($urandom_range(3) == 0);
      return r;
   endfunction

   // sender gap of a random number of cycles
   task automatic pause_sender();
      int n;
      n = 0;
      while (n < 20 && $urandom_range(99) < send_idle_pct) n++;
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_request(input req_payload_type item, input bit use_typed,
                               input rsp_payload_type typed_rsp);
      bit              emits;
      rsp_payload_type predicted;
      req_payload <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_smoother(item, emits, predicted);
      if (emits) smoothed_due.push_back(use_typed ? typed_rsp : predicted);
   endtask

   // hold the sender until every result is back and the block has gone quiet
   task automatic wait_until_settled();
      req_valid <= 1'b0;
      while (smoothed_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_order(input logic [2:0] value);
      wait_until_settled();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      order_reg = value;
   endtask

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (smoothed_due.size() == 0) begin
            $error("unexpected result transaction: index %0d x %h y %h",
                   rsp_payload.out_index, rsp_payload.out_x, rsp_payload.out_y);
            mismatch_count++;
         end else begin
            due_point = smoothed_due.pop_front();
            if (rsp_payload.out_index !== due_point.out_index) begin
               $error("out_index expected %0d got %0d", due_point.out_index,
                      rsp_payload.out_index);
               mismatch_count++;
            end
            if (rsp_payload.out_x !== due_point.out_x) begin
               $error("out_x expected %h got %h", due_point.out_x, rsp_payload.out_x);
               mismatch_count++;
            end
            if (rsp_payload.out_y !== due_point.out_y) begin
               $error("out_y expected %h got %h", due_point.out_y, rsp_payload.out_y);
               mismatch_count++;
            end
            if (rsp_payload.out_last !== due_point.out_last) begin
               $error("out_last expected %0d got %0d", due_point.out_last,
                      rsp_payload.out_last);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      req_payload_type item;
      rsp_payload_type typed_rsp;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      event_seen = 1'b0;
      order_reg = ORDER_RESET;
      send_idle_pct = 36;
      recv_idle_pct = 70;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // give every element a destination inside one open event, so no later
      // transaction reads an entry that was never written
      for (int i = 0; i < POINT_COUNT; i++) begin
         item = random_request();
         item.command = CMD_SET_DEST;
         item.element_index = 8'(i);
         item.last_element = 1'b0;
         pause_sender();
         send_request(item, 1'b0, '0);
      end

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         if (steps[r].order != order_reg) write_order(steps[r].order);
         item.command = steps[r].cmd;
         item.element_index = steps[r].idx;
         item.coord_x = steps[r].x;
         item.coord_y = steps[r].y;
         item.smoothing_factor = steps[r].alpha;
         item.last_element = steps[r].last;
         typed_rsp.out_index = steps[r].idx;
         typed_rsp.out_x = steps[r].ex;
         typed_rsp.out_y = steps[r].ey;
         typed_rsp.out_last = steps[r].last;
         pause_sender();
         send_request(item, steps[r].typed, typed_rsp);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph / 3)
            0: begin
               send_idle_pct = 36;
               recv_idle_pct = 70;
            end
            1: begin
               send_idle_pct = 70;
               recv_idle_pct = 36;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         write_order(PHASE_ORDER[ph]);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (ph == 4 && n == ITEMS_PER_PHASE / 2) wait_until_settled();
            pause_sender();
            send_request(random_request(), 1'b0, '0);
         end
      end

      wait_until_settled();
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
